### design/fdtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd_pkg
// Shared constants, types and command structures of the 2D TMz field update.
// ----------------------------------------------------------------------------
package fdtd_pkg;

  // Grid storage limits.
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = X_W + Y_W;
  localparam int DEPTH      = 1 << ADDR_W;
  localparam int DIMX_W     = X_W + 1;
  localparam int DIMY_W     = Y_W + 1;

  // Arithmetic formats: fields Q4.28, coefficients Q10.22.
  localparam int FIELD_W    = 32;
  localparam int FRAC_SHIFT = 22;
  localparam int PROD_W     = 2 * FIELD_W;
  localparam int TERM_W     = PROD_W - FRAC_SHIFT;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_H_SELF      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_H_FROM_E    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_E_SELF      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_E_FROM_H    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_X    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_Y    = 3'd7;

  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic signed [FIELD_W-1:0] field_t;

  // Which field update the shared multiply chain is working on.
  typedef enum logic [1:0] {
    UPD_HX,
    UPD_HY,
    UPD_EZ
  } upd_t;

  // Write data source for the field memories.
  typedef enum logic [1:0] {
    WD_RES,
    WD_ZERO,
    WD_SAMPLE
  } wd_sel_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RC,
    ST_RN1,
    ST_RN2,
    ST_CAP,
    ST_DIFF,
    ST_CURL,
    ST_M1,
    ST_M2,
    ST_MT,
    ST_SUM,
    ST_WR,
    ST_ENTER,
    ST_EDGE,
    ST_SRC,
    ST_PRB_RD,
    ST_PRB_CAP,
    ST_DONE
  } state_t;

  typedef struct packed {
    field_t h_self;
    field_t h_from_e;
    field_t e_self;
    field_t e_from_h;
  } coef_t;

  typedef struct packed {
    addr_t   rd_addr;
    addr_t   wr_addr;
    logic    we_ez;
    logic    we_hx;
    logic    we_hy;
    wd_sel_t wd_sel;
    logic    load_in;
    logic    cap_c;
    logic    cap_n1;
    logic    cap_n2;
    logic    mode_e;
    logic    diff;
    logic    en1;
    logic    en2;
    logic    curl;
    logic    mul_a;
    logic    mul_b;
    logic    term_b;
    logic    sum;
    upd_t    upd;
    logic    out_load;
    logic    probe_in;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

### design/fdtd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module fdtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/fdtd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd_dp
// Datapath: field memories, operand registers, saturating differences, one
// shared multiplier, the update sum, the sticky overflow flag and the result
// register.
// ----------------------------------------------------------------------------
module fdtd_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  fdtd_pkg::dp_cmd_t   cmd,
  input  fdtd_pkg::coef_t     coef,
  input  fdtd_pkg::field_t    in_sample,
  output fdtd_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output fdtd_pkg::field_t    out_probe_ez,
  output logic                out_overflow
);
  import fdtd_pkg::*;

  field_t ez_q, hx_q, hy_q, wdata;
  field_t sample_r, ez0_r, hx0_r, hy0_r, n1_r, n2_r, d1_r, d2_r, curl_r, res_r;
  field_t op_coef, op_field, probe_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [TERM_W-1:0] term_a_r, term_b_r;
  logic signed [FIELD_W:0]  d1_raw, d2_raw, curl_raw;
  logic signed [TERM_W:0]   sum_raw;
  logic ovf_r, ovf_nxt, out_valid_r, out_valid_nxt;
  logic ovf_out_r;

  function automatic field_t sat_diff(input logic signed [FIELD_W:0] v);
    if (v[FIELD_W] != v[FIELD_W-1]) begin
      return v[FIELD_W] ? {1'b1, {(FIELD_W-1){1'b0}}} : {1'b0, {(FIELD_W-1){1'b1}}};
    end
    return v[FIELD_W-1:0];
  endfunction

  function automatic logic of_diff(input logic signed [FIELD_W:0] v);
    return v[FIELD_W] != v[FIELD_W-1];
  endfunction

  function automatic logic of_sum(input logic signed [TERM_W:0] v);
    return !((&v[TERM_W:FIELD_W-1]) || (~|v[TERM_W:FIELD_W-1]));
  endfunction

  function automatic field_t sat_sum(input logic signed [TERM_W:0] v);
    if (of_sum(v)) begin
      return v[TERM_W] ? {1'b1, {(FIELD_W-1){1'b0}}} : {1'b0, {(FIELD_W-1){1'b1}}};
    end
    return v[FIELD_W-1:0];
  endfunction

  // Memory write data selection.
  always_comb begin
    unique case (cmd.wd_sel)
      WD_RES:    wdata = res_r;
      WD_SAMPLE: wdata = sample_r;
      default:   wdata = '0;
    endcase
  end

  fdtd_ram #(.WIDTH(FIELD_W), .DEPTH(DEPTH)) u_ez_ram (
    .clk(clk), .we(cmd.we_ez), .waddr(cmd.wr_addr), .wdata(wdata),
    .raddr(cmd.rd_addr), .rdata(ez_q)
  );

  fdtd_ram #(.WIDTH(FIELD_W), .DEPTH(DEPTH)) u_hx_ram (
    .clk(clk), .we(cmd.we_hx), .waddr(cmd.wr_addr), .wdata(wdata),
    .raddr(cmd.rd_addr), .rdata(hx_q)
  );

  fdtd_ram #(.WIDTH(FIELD_W), .DEPTH(DEPTH)) u_hy_ram (
    .clk(clk), .we(cmd.we_hy), .waddr(cmd.wr_addr), .wdata(wdata),
    .raddr(cmd.rd_addr), .rdata(hy_q)
  );

  // Differences: the H pass takes Ez gradients, the E pass H differences.
  always_comb begin
    if (cmd.mode_e) begin
      d1_raw = {hx0_r[FIELD_W-1], hx0_r} - {n1_r[FIELD_W-1], n1_r};
      d2_raw = {hy0_r[FIELD_W-1], hy0_r} - {n2_r[FIELD_W-1], n2_r};
    end else begin
      d1_raw = {n1_r[FIELD_W-1], n1_r} - {ez0_r[FIELD_W-1], ez0_r};
      d2_raw = {n2_r[FIELD_W-1], n2_r} - {ez0_r[FIELD_W-1], ez0_r};
    end
    curl_raw = {d2_r[FIELD_W-1], d2_r} - {d1_r[FIELD_W-1], d1_r};
  end

  // Multiplier operand selection for the self term and the curl term.
  always_comb begin
    unique case (cmd.upd)
      UPD_HX: begin
        op_coef  = cmd.mul_b ? coef.h_from_e : coef.h_self;
        op_field = cmd.mul_b ? d1_r : hx0_r;
      end
      UPD_HY: begin
        op_coef  = cmd.mul_b ? coef.h_from_e : coef.h_self;
        op_field = cmd.mul_b ? d2_r : hy0_r;
      end
      default: begin
        op_coef  = cmd.mul_b ? coef.e_from_h : coef.e_self;
        op_field = cmd.mul_b ? curl_r : ez0_r;
      end
    endcase
  end

  // The Hx update subtracts its curl term; the others add it.
  always_comb begin
    if (cmd.upd == UPD_HX) begin
      sum_raw = {term_a_r[TERM_W-1], term_a_r} - {term_b_r[TERM_W-1], term_b_r};
    end else begin
      sum_raw = {term_a_r[TERM_W-1], term_a_r} + {term_b_r[TERM_W-1], term_b_r};
    end
  end

  // Sticky overflow flag.
  always_comb begin
    ovf_nxt = ovf_r;
    if (cmd.diff && ((cmd.en1 && of_diff(d1_raw)) || (cmd.en2 && of_diff(d2_raw)))) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.curl && of_diff(curl_raw)) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.sum && of_sum(sum_raw)) begin
      ovf_nxt = 1'b1;
    end
  end

  // Result register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample_r <= in_sample;
    end
    if (cmd.cap_c) begin
      ez0_r <= ez_q;
      hx0_r <= hx_q;
      hy0_r <= hy_q;
    end
    if (cmd.cap_n1) begin
      n1_r <= cmd.mode_e ? hx_q : ez_q;
    end
    if (cmd.cap_n2) begin
      n2_r <= cmd.mode_e ? hy_q : ez_q;
    end
    if (cmd.diff) begin
      d1_r <= sat_diff(d1_raw);
      d2_r <= sat_diff(d2_raw);
    end
    if (cmd.curl) begin
      curl_r <= sat_diff(curl_raw);
    end
    if (cmd.mul_a || cmd.mul_b) begin
      prod_r <= PROD_W'(op_coef) * PROD_W'(op_field);
    end
    if (cmd.mul_b) begin
      term_a_r <= prod_r[PROD_W-1:FRAC_SHIFT];
    end
    if (cmd.term_b) begin
      term_b_r <= prod_r[PROD_W-1:FRAC_SHIFT];
    end
    if (cmd.sum) begin
      res_r <= sat_sum(sum_raw);
    end
    // The flag travels with its result, so a waiting beat stays unchanged.
    if (cmd.out_load) begin
      probe_r   <= cmd.probe_in ? ez0_r : '0;
      ovf_out_r <= ovf_r;
    end
  end

  assign status.out_busy = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_probe_ez    = probe_r;
  assign out_overflow    = ovf_out_r;

endmodule

### design/fdtd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd_ctrl
// Controller: clearing pass, grid sweep counters and the per-cell sequence of
// reads, arithmetic steps and writes for the H pass and the E pass.
// ----------------------------------------------------------------------------
module fdtd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_drive,
  input  logic [6:0]           in_probe_x,
  input  logic [6:0]           in_probe_y,
  input  logic [7:0]           grid_width,
  input  logic [7:0]           grid_height,
  input  logic [6:0]           source_x,
  input  logic [6:0]           source_y,
  input  fdtd_pkg::dp_status_t status,
  output fdtd_pkg::dp_cmd_t    cmd
);
  import fdtd_pkg::*;

  state_t state_r, state_nxt;
  logic [X_W-1:0] x_r, x_nxt;
  logic [Y_W-1:0] y_r, y_nxt;
  logic pass_e_r, pass_e_nxt;
  upd_t upd_r, upd_nxt;
  addr_t clr_r, clr_nxt;
  logic drive_r, drive_nxt;
  logic [6:0] px_r, px_nxt, py_r, py_nxt;
  logic [DIMX_W-1:0] w;
  logic [DIMY_W-1:0] h;
  logic xlast, ylast, is_edge, advance, src_in, probe_in;
  addr_t center;

  function automatic addr_t mk_addr(input logic [X_W-1:0] x, input logic [Y_W-1:0] y);
    return {x, y};
  endfunction

  // Used grid size, clamped to at least 3 and at most the storage limits.
  always_comb begin
    if (grid_width < 8'd3) begin
      w = DIMX_W'(3);
    end else if (32'(grid_width) > 32'(MAX_WIDTH)) begin
      w = DIMX_W'(MAX_WIDTH);
    end else begin
      w = DIMX_W'(grid_width);
    end
    if (grid_height < 8'd3) begin
      h = DIMY_W'(3);
    end else if (32'(grid_height) > 32'(MAX_HEIGHT)) begin
      h = DIMY_W'(MAX_HEIGHT);
    end else begin
      h = DIMY_W'(grid_height);
    end
  end

  // Cell position flags.
  assign xlast    = (DIMX_W'(x_r) + DIMX_W'(1)) == w;
  assign ylast    = (DIMY_W'(y_r) + DIMY_W'(1)) == h;
  assign is_edge  = (x_r == '0) || (y_r == '0) || xlast || ylast;
  assign center   = mk_addr(x_r, y_r);
  assign src_in   = drive_r && (32'(source_x) < 32'(w)) && (32'(source_y) < 32'(h));
  assign probe_in = (32'(px_r) < 32'(w)) && (32'(py_r) < 32'(h));

  // Next state and counters.
  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    pass_e_nxt = pass_e_r;
    upd_nxt    = upd_r;
    clr_nxt    = clr_r;
    drive_nxt  = drive_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    advance    = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + addr_t'(1);
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          drive_nxt  = in_drive;
          px_nxt     = in_probe_x;
          py_nxt     = in_probe_y;
          x_nxt      = '0;
          y_nxt      = '0;
          pass_e_nxt = 1'b0;
          state_nxt  = ST_RC;
        end
      end
      ST_RC:  state_nxt = ST_RN1;
      ST_RN1: state_nxt = ST_RN2;
      ST_RN2: state_nxt = ST_CAP;
      ST_CAP: state_nxt = ST_DIFF;
      ST_DIFF: begin
        if (pass_e_r) begin
          state_nxt = ST_CURL;
        end else if (!ylast) begin
          upd_nxt   = UPD_HX;
          state_nxt = ST_M1;
        end else if (!xlast) begin
          upd_nxt   = UPD_HY;
          state_nxt = ST_M1;
        end else begin
          advance = 1'b1;
        end
      end
      ST_CURL: begin
        upd_nxt   = UPD_EZ;
        state_nxt = ST_M1;
      end
      ST_M1:  state_nxt = ST_M2;
      ST_M2:  state_nxt = ST_MT;
      ST_MT:  state_nxt = ST_SUM;
      ST_SUM: state_nxt = ST_WR;
      ST_WR: begin
        if (upd_r == UPD_HX && !xlast) begin
          upd_nxt   = UPD_HY;
          state_nxt = ST_M1;
        end else begin
          advance = 1'b1;
        end
      end
      ST_ENTER: state_nxt = is_edge ? ST_EDGE : ST_RC;
      ST_EDGE:  advance   = 1'b1;
      ST_SRC:     state_nxt = ST_PRB_RD;
      ST_PRB_RD:  state_nxt = ST_PRB_CAP;
      ST_PRB_CAP: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Step to the next cell, column by column, then to the E pass or, after it, the source step.
    if (advance) begin
      if (ylast && xlast) begin
        x_nxt = '0;
        y_nxt = '0;
        if (!pass_e_r) begin
          pass_e_nxt = 1'b1;
          state_nxt  = ST_ENTER;
        end else begin
          state_nxt = ST_SRC;
        end
      end else begin
        if (ylast) begin
          y_nxt = '0;
          x_nxt = x_r + X_W'(1);
        end else begin
          y_nxt = y_r + Y_W'(1);
        end
        state_nxt = pass_e_r ? ST_ENTER : ST_RC;
      end
    end
  end

  // Datapath commands.
  always_comb begin
    cmd          = '0;
    cmd.rd_addr  = center;
    cmd.wr_addr  = center;
    cmd.wd_sel   = WD_RES;
    cmd.mode_e   = pass_e_r;
    cmd.upd      = upd_r;
    cmd.probe_in = probe_in;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.wr_addr = clr_r;
        cmd.wd_sel  = WD_ZERO;
        cmd.we_ez   = 1'b1;
        cmd.we_hx   = 1'b1;
        cmd.we_hy   = 1'b1;
      end
      ST_IDLE: cmd.load_in = in_valid;
      ST_RN1: begin
        cmd.cap_c   = 1'b1;
        cmd.rd_addr = pass_e_r ? mk_addr(x_r, y_r - Y_W'(1)) : mk_addr(x_r, y_r + Y_W'(1));
      end
      ST_RN2: begin
        cmd.cap_n1  = 1'b1;
        cmd.rd_addr = pass_e_r ? mk_addr(x_r - X_W'(1), y_r) : mk_addr(x_r + X_W'(1), y_r);
      end
      ST_CAP: cmd.cap_n2 = 1'b1;
      ST_DIFF: begin
        cmd.diff = 1'b1;
        cmd.en1  = pass_e_r || !ylast;
        cmd.en2  = pass_e_r || !xlast;
      end
      ST_CURL: cmd.curl   = 1'b1;
      ST_M1:   cmd.mul_a  = 1'b1;
      ST_M2:   cmd.mul_b  = 1'b1;
      ST_MT:   cmd.term_b = 1'b1;
      ST_SUM:  cmd.sum    = 1'b1;
      ST_WR: begin
        cmd.we_hx = (upd_r == UPD_HX);
        cmd.we_hy = (upd_r == UPD_HY);
        cmd.we_ez = (upd_r == UPD_EZ);
      end
      ST_EDGE: begin
        cmd.wd_sel = WD_ZERO;
        cmd.we_ez  = 1'b1;
      end
      ST_SRC: begin
        cmd.wr_addr = mk_addr(X_W'(source_x), Y_W'(source_y));
        cmd.wd_sel  = WD_SAMPLE;
        cmd.we_ez   = src_in;
      end
      ST_PRB_RD:  cmd.rd_addr = mk_addr(X_W'(px_r), Y_W'(py_r));
      ST_PRB_CAP: cmd.cap_c   = 1'b1;
      ST_DONE:    cmd.out_load = !status.out_busy;
      default: ;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      x_r      <= '0;
      y_r      <= '0;
      pass_e_r <= 1'b0;
      upd_r    <= UPD_HX;
      clr_r    <= '0;
      drive_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      pass_e_r <= pass_e_nxt;
      upd_r    <= upd_nxt;
      clr_r    <= clr_nxt;
      drive_r  <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    py_r <= py_nxt;
  end

`ifndef ASSERT_OFF
  // An accepted beat starts the H pass at the first cell.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && in_valid |=> state_r == ST_RC && x_r == '0 && y_r == '0)
    else $error("accepted beat did not start the H pass");

  // Ez updates only happen during the E pass.
  a_ez_in_e: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR && upd_r == UPD_EZ |-> pass_e_r)
    else $error("Ez update outside the E pass");

  // The clearing pass only ends into idle.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |=> state_r == ST_CLEAR || state_r == ST_IDLE)
    else $error("clearing pass left early");
`endif

endmodule

### design/fdtd_2d_tmz_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd_2d_tmz_step
// One time step of a fixed-point 2D TMz Yee grid per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   Write the grid size, coefficients and source position on the cfg_ port
//   while the block is idle. Each input beat carries one source sample, the
//   drive flag and the probe cell; the block updates all Hx/Hy cells, then
//   all Ez cells, optionally forces the source cell, and returns one output
//   beat with the new Ez at the probe cell and the sticky overflow flag.
//   In the H pass every cell is read, Hx is updated off the last y row and
//   Hy off the last x column; in the E pass interior cells get a new Ez and
//   edge cells are zeroed. All updates share a single multiplier, and each
//   field memory has one read port.
//   One beat is in work at a time; in_tready is high only while idle.
//   After reset a clearing pass zeroes all 16384 words of each field memory;
//   no beat is accepted until it finishes. The result sits in an output
//   register: a stalled receiver holds the next result at its final step,
//   but the following input beat can already be accepted.
// ----------------------------------------------------------------------------
module fdtd_2d_tmz_step (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: source_value[31:0], drive_source[32], probe_x[39:33],
  // probe_y[46:40], zero[47]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [47:0]                    in_tdata,
  // out_tdata: probe_ez[31:0], overflow_seen[32], zero[39:33]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [39:0]                    out_tdata,
  input  logic                           cfg_we,
  input  logic [fdtd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);
  import fdtd_pkg::*;

  logic [7:0] grid_width_r, grid_height_r;
  logic [6:0] source_x_r, source_y_r;
  coef_t coef_r;
  dp_cmd_t cmd;
  dp_status_t status;
  field_t probe_ez;
  logic overflow;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r    <= 8'd101;
      grid_height_r   <= 8'd81;
      coef_r.h_self   <= 32'sd4194304;
      coef_r.h_from_e <= 32'sd7866;
      coef_r.e_self   <= 32'sd4194304;
      coef_r.e_from_h <= 32'sd1118148934;
      source_x_r      <= 7'd50;
      source_y_r      <= 7'd40;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r    <= cfg_wdata[7:0];
        REG_GRID_HEIGHT: grid_height_r   <= cfg_wdata[7:0];
        REG_H_SELF:      coef_r.h_self   <= cfg_wdata;
        REG_H_FROM_E:    coef_r.h_from_e <= cfg_wdata;
        REG_E_SELF:      coef_r.e_self   <= cfg_wdata;
        REG_E_FROM_H:    coef_r.e_from_h <= cfg_wdata;
        REG_SOURCE_X:    source_x_r      <= cfg_wdata[6:0];
        REG_SOURCE_Y:    source_y_r      <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  fdtd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_drive    (in_tdata[32]),
    .in_probe_x  (in_tdata[39:33]),
    .in_probe_y  (in_tdata[46:40]),
    .grid_width  (grid_width_r),
    .grid_height (grid_height_r),
    .source_x    (source_x_r),
    .source_y    (source_y_r),
    .status      (status),
    .cmd         (cmd)
  );

  fdtd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .coef         (coef_r),
    .in_sample    (in_tdata[31:0]),
    .status       (status),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_probe_ez (probe_ez),
    .out_overflow (overflow)
  );

  assign out_tdata = {7'd0, overflow, probe_ez};

endmodule
